// ===== rtl/ehs_pkg.sv =====
// Shared types and constants of the extendible-hashing set.
`timescale 1ns / 1ps
package ehs_pkg;

  localparam int KeyW      = 16;
  localparam int CapW      = 4;
  localparam int StatusW   = 3;
  localparam int DepthOutW = 4;
  localparam logic [CapW-1:0] CapReset = 4'd4;

  // Request codes
  localparam logic ReqInsert = 1'b0;
  localparam logic ReqLookup = 1'b1;

  // Result codes
  localparam logic [StatusW-1:0] StInserted  = 3'd0;
  localparam logic [StatusW-1:0] StDuplicate = 3'd1;
  localparam logic [StatusW-1:0] StFound     = 3'd2;
  localparam logic [StatusW-1:0] StNotFound  = 3'd3;
  localparam logic [StatusW-1:0] StFull      = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DIR_RD,
    S_DIR_WAIT,
    S_FILL_WAIT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_INS_CHK,
    S_SPLIT,
    S_DBL_RD,
    S_DBL_WR,
    S_RED_RD,
    S_RED_WR,
    S_FILL_OLD,
    S_FILL_NEW,
    S_REPOINT,
    S_DONE
  } ehs_state_e;

endpackage

// ===== rtl/extendible_hash_set.sv =====
// Extendible-hashing key set: directory, bucket fill and bucket key memories with a sequencer.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid_i in_stall_o req_type_i key_i | beat in
//  out     | out_valid_o out_stall_i status_o depth_now_o | beat out
//  cfg     | cfg_we_i cfg_wdata_i                  | write only
//
// One request at a time: a request reads the directory entry, the bucket fill
// and then the bucket's keys in turn; the next beat is taken once the result
// is in the output register. Each split moves keys, writes both fill counts and
// repoints the directory, copying every live entry first when it doubles;
// every memory has one read port with a registered read.
// After reset the table holds two empty buckets of depth one; no clearing pass.
// A finished result waits in the output register while the next beat is taken.
`timescale 1ns / 1ps
module extendible_hash_set #(
  parameter int KEY_BITS     = 16,
  parameter int MAX_DEPTH    = 10,
  parameter int BUCKET_SLOTS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           req_type_i,
  input  logic [ehs_pkg::KeyW-1:0]       key_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ehs_pkg::StatusW-1:0]    status_o,
  output logic [ehs_pkg::DepthOutW-1:0]  depth_now_o,
  input  logic                           cfg_we_i,
  input  logic [ehs_pkg::CapW-1:0]       cfg_wdata_i
);
  import ehs_pkg::*;

  localparam int KW      = (KEY_BITS < KeyW) ? KEY_BITS : KeyW;
  localparam int DIR_W   = MAX_DEPTH;
  localparam int NUM     = 1 << MAX_DEPTH;
  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int FILL_W  = $clog2(BUCKET_SLOTS + 1);
  localparam int KDEPTH  = NUM * BUCKET_SLOTS;
  localparam int KA_W    = $clog2(KDEPTH);
  localparam int CMP_W   = (FILL_W > CapW) ? FILL_W + 1 : CapW + 1;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [DIR_W-1:0]   bucket;
  } dir_entry_t;

  // Memories
  dir_entry_t        dir_mem  [NUM];
  logic [FILL_W-1:0] fill_mem [NUM];
  logic [KW-1:0]     key_mem  [KDEPTH];

  ehs_state_e state_q, state_d;

  logic [DEPTH_W-1:0] gd_q;
  logic [DIR_W:0]     used_q;
  logic [CapW-1:0]    cap_q;
  logic               out_valid_q;
  logic [1:0]         dir_wdone_q, fill_wdone_q;

  logic               req_q, scanned_q;
  logic [KW-1:0]      key_q;
  logic [DIR_W-1:0]   idx_q, oldb_q, newb_q;
  logic [DEPTH_W-1:0] ld_q;
  logic [FILL_W-1:0]  fill_q, j_q, w_q, n_q;
  logic [DIR_W:0]     i_q;
  logic [StatusW-1:0] status_q, out_status_q;
  logic [DEPTH_W-1:0] out_depth_q;

  dir_entry_t         dir_rdata_q;
  logic [FILL_W-1:0]  fill_rdata_q;
  logic [KW-1:0]      key_rdata_q;
  logic               dir_rd_init_q, dir_rd_lsb_q, fill_rd_init_q;

  logic               dir_re, dir_we, fill_re, fill_we, key_re, key_we;
  logic [DIR_W-1:0]   dir_raddr, dir_waddr, fill_raddr, fill_waddr;
  dir_entry_t         dir_wdata;
  logic [FILL_W-1:0]  fill_wdata;
  logic [KA_W-1:0]    key_raddr, key_waddr;
  logic [KW-1:0]      key_wdata;

  dir_entry_t         dir_rd;
  logic [FILL_W-1:0]  fill_rd, eff_cap;
  logic [DIR_W:0]     live, step, gd_mask, ld_mask;
  logic [DIR_W-1:0]   idx_now, base;
  logic [DIR_W+KW-1:0] key_ext, rd_ext;
  logic               rd_bit, rp_bit, out_free, in_acc;

  // Unwritten entries 0 and 1 read as their reset values
  always_comb begin
    dir_rd = dir_rdata_q;
    if (dir_rd_init_q) begin
      dir_rd.depth  = DEPTH_W'(1);
      dir_rd.bucket = DIR_W'(dir_rd_lsb_q);
    end
  end
  assign fill_rd = fill_rd_init_q ? '0 : fill_rdata_q;

  // Clamp capacity to [1, BUCKET_SLOTS]
  always_comb begin
    priority if (cap_q == '0) eff_cap = FILL_W'(1);
    else if (CMP_W'(cap_q) > CMP_W'(BUCKET_SLOTS)) eff_cap = FILL_W'(BUCKET_SLOTS);
    else eff_cap = FILL_W'(cap_q);
  end

  assign live    = (DIR_W+1)'(1) << gd_q;
  assign step    = (DIR_W+1)'(1) << ld_q;
  assign gd_mask = live - (DIR_W+1)'(1);
  assign ld_mask = step - (DIR_W+1)'(1);
  assign key_ext = (DIR_W+KW)'(key_q);
  assign rd_ext  = (DIR_W+KW)'(key_rdata_q) >> ld_q;
  assign rd_bit  = rd_ext[0];
  assign idx_now = key_ext[DIR_W-1:0] & gd_mask[DIR_W-1:0];
  assign base    = idx_q & ld_mask[DIR_W-1:0];
  always_comb begin
    logic [DIR_W:0] sh;
    sh     = i_q >> ld_q;
    rp_bit = sh[0];
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (in_acc) state_d = S_DIR_RD;
      S_DIR_RD:    state_d = S_DIR_WAIT;
      S_DIR_WAIT:  state_d = S_FILL_WAIT;
      S_FILL_WAIT: state_d = scanned_q ? S_INS_CHK : S_SCAN_RD;
      S_SCAN_RD: begin
        if (j_q < fill_q) state_d = S_SCAN_CMP;
        else if (req_q == ReqLookup) state_d = S_DONE;
        else state_d = S_INS_CHK;
      end
      S_SCAN_CMP:  state_d = (key_rdata_q == key_q) ? S_DONE : S_SCAN_RD;
      S_INS_CHK:   state_d = (fill_q < eff_cap) ? S_DONE : S_SPLIT;
      S_SPLIT: begin
        priority if (ld_q >= gd_q) begin
          state_d = (gd_q >= DEPTH_W'(MAX_DEPTH)) ? S_DONE : S_DBL_RD;
        end else if (used_q >= (DIR_W+1)'(NUM)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_RED_RD;
        end
      end
      S_DBL_RD:    state_d = S_DBL_WR;
      S_DBL_WR:    state_d = (i_q + (DIR_W+1)'(1) == live) ? S_SPLIT : S_DBL_RD;
      S_RED_RD:    state_d = (j_q < fill_q) ? S_RED_WR : S_FILL_OLD;
      S_RED_WR:    state_d = S_RED_RD;
      S_FILL_OLD:  state_d = S_FILL_NEW;
      S_FILL_NEW:  state_d = S_REPOINT;
      S_REPOINT:   state_d = (i_q < live) ? S_REPOINT : S_DIR_RD;
      S_DONE:      if (out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // Memory strobes, addresses and write data
  always_comb begin
    dir_re     = 1'b0;
    dir_raddr  = idx_now;
    dir_we     = 1'b0;
    dir_waddr  = i_q[DIR_W-1:0];
    dir_wdata  = dir_rd;
    fill_re    = 1'b0;
    fill_raddr = dir_rd.bucket;
    fill_we    = 1'b0;
    fill_waddr = oldb_q;
    fill_wdata = w_q;
    key_re     = 1'b0;
    key_raddr  = KA_W'(oldb_q) * KA_W'(BUCKET_SLOTS) + KA_W'(j_q);
    key_we     = 1'b0;
    key_waddr  = KA_W'(oldb_q) * KA_W'(BUCKET_SLOTS) + KA_W'(fill_q);
    key_wdata  = key_q;
    unique case (state_q)
      S_DIR_RD:   dir_re = 1'b1;
      S_DIR_WAIT: fill_re = 1'b1;
      S_SCAN_RD:  key_re = (j_q < fill_q);
      S_INS_CHK: begin
        key_we     = (fill_q < eff_cap);
        fill_we    = (fill_q < eff_cap);
        fill_wdata = fill_q + FILL_W'(1);
      end
      S_DBL_RD: begin
        dir_re    = 1'b1;
        dir_raddr = i_q[DIR_W-1:0];
      end
      S_DBL_WR: begin
        dir_we    = 1'b1;
        dir_waddr = i_q[DIR_W-1:0] + live[DIR_W-1:0];
      end
      S_RED_RD:   key_re = (j_q < fill_q);
      S_RED_WR: begin
        key_we    = 1'b1;
        key_wdata = key_rdata_q;
        key_waddr = rd_bit ? KA_W'(newb_q) * KA_W'(BUCKET_SLOTS) + KA_W'(n_q)
                           : KA_W'(oldb_q) * KA_W'(BUCKET_SLOTS) + KA_W'(w_q);
      end
      S_FILL_OLD: fill_we = 1'b1;
      S_FILL_NEW: begin
        fill_we    = 1'b1;
        fill_waddr = newb_q;
        fill_wdata = n_q;
      end
      S_REPOINT: begin
        dir_we           = (i_q < live);
        dir_wdata.depth  = ld_q + DEPTH_W'(1);
        dir_wdata.bucket = rp_bit ? newb_q : oldb_q;
      end
      default: ;
    endcase
  end

  // Memory arrays with registered reads
  always_ff @(posedge clk_i) begin
    if (dir_we) dir_mem[dir_waddr] <= dir_wdata;
    if (dir_re) dir_rdata_q <= dir_mem[dir_raddr];
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    if (fill_re) fill_rdata_q <= fill_mem[fill_raddr];
    if (key_we) key_mem[key_waddr] <= key_wdata;
    if (key_re) key_rdata_q <= key_mem[key_raddr];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      gd_q           <= DEPTH_W'(1);
      used_q         <= (DIR_W+1)'(2);
      cap_q          <= CapReset;
      out_valid_q    <= 1'b0;
      dir_wdone_q    <= '0;
      fill_wdone_q   <= '0;
      dir_rd_init_q  <= 1'b0;
      fill_rd_init_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (state_q == S_DBL_WR && state_d == S_SPLIT) gd_q <= gd_q + DEPTH_W'(1);
      if (state_q == S_SPLIT && state_d == S_RED_RD) used_q <= used_q + (DIR_W+1)'(1);
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (dir_we && dir_waddr < DIR_W'(2)) dir_wdone_q[dir_waddr[0]] <= 1'b1;
      if (fill_we && fill_waddr < DIR_W'(2)) fill_wdone_q[fill_waddr[0]] <= 1'b1;
      if (dir_re) begin
        dir_rd_init_q <= (dir_raddr < DIR_W'(2)) && !dir_wdone_q[dir_raddr[0]];
      end
      if (fill_re) begin
        fill_rd_init_q <= (fill_raddr < DIR_W'(2)) && !fill_wdone_q[fill_raddr[0]];
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (dir_re) dir_rd_lsb_q <= dir_raddr[0];
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          req_q     <= req_type_i;
          key_q     <= key_i[KW-1:0];
          scanned_q <= 1'b0;
        end
      end
      S_DIR_RD: idx_q <= idx_now;
      S_DIR_WAIT: begin
        ld_q   <= dir_rd.depth;
        oldb_q <= dir_rd.bucket;
      end
      S_FILL_WAIT: begin
        fill_q <= fill_rd;
        j_q    <= '0;
      end
      S_SCAN_RD: begin
        if (!(j_q < fill_q)) begin
          status_q  <= StNotFound;
          scanned_q <= 1'b1;
        end
      end
      S_SCAN_CMP: begin
        j_q      <= j_q + FILL_W'(1);
        status_q <= (req_q == ReqLookup) ? StFound : StDuplicate;
      end
      S_INS_CHK: status_q <= StInserted;
      S_SPLIT: begin
        status_q <= StFull;
        i_q      <= '0;
        newb_q   <= used_q[DIR_W-1:0];
        j_q      <= '0;
        w_q      <= '0;
        n_q      <= '0;
      end
      S_DBL_WR: i_q <= i_q + (DIR_W+1)'(1);
      S_RED_WR: begin
        j_q <= j_q + FILL_W'(1);
        if (rd_bit) n_q <= n_q + FILL_W'(1);
        else w_q <= w_q + FILL_W'(1);
      end
      S_FILL_NEW: i_q <= (DIR_W+1)'(base);
      S_REPOINT:  i_q <= i_q + step;
      S_DONE: begin
        if (out_free) begin
          out_status_q <= status_q;
          out_depth_q  <= gd_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign depth_now_o = DepthOutW'(out_depth_q);

  // Checks
  a_gd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gd_q >= DEPTH_W'(1) && gd_q <= DEPTH_W'(MAX_DEPTH))
    else $error("global depth out of range");
  a_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= (DIR_W+1)'(NUM) && used_q <= live)
    else $error("bucket count exceeds directory size");
  a_gd_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gd_q != $past(gd_q) |-> $past(state_q) == S_DBL_WR)
    else $error("global depth changed outside doubling");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> out_status_q <= StFull)
    else $error("bad status code");

endmodule

// ===== sim/extendible_hash_set_tb.sv =====
// Self-checking testbench for the extendible-hashing key set.
`timescale 1ns / 1ps
module extendible_hash_set_tb;
  import ehs_pkg::*;

  localparam int MaxDepth   = 10;
  localparam int DirEntries = 1 << MaxDepth;
  localparam int Slots      = 8;
  localparam int CycleLimit = 1000000;

  typedef struct packed {
    logic [StatusW-1:0]   status;
    logic [DepthOutW-1:0] depth;
  } set_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 req_type_i = ReqInsert;
  logic [KeyW-1:0]      key_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [StatusW-1:0]   status_o;
  logic [DepthOutW-1:0] depth_now_o;
  logic                 cfg_we_i = 1'b0;
  logic [CapW-1:0]      cfg_wdata_i = '0;

  // Shadow copy of the table
  int          shadow_gdepth;
  int          shadow_used;
  int          shadow_cap;
  int          dir_depth [DirEntries];
  int          dir_bucket[DirEntries];
  int          bucket_fill[DirEntries];
  logic [KeyW-1:0] bucket_key[DirEntries][Slots];

  set_result_t     pending_results[$];
  logic [KeyW-1:0] stored_keys[$];
  int              mismatch_count = 0;
  int              cycle_count = 0;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  int              hold_cycles = 0;

  extendible_hash_set dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i, .key_i,
    .out_valid_o, .out_stall_i, .status_o, .depth_now_o, .cfg_we_i, .cfg_wdata_i
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int dir_slot(logic [KeyW-1:0] k);
    return int'(k) & ((1 << shadow_gdepth) - 1);
  endfunction

  function automatic bit key_present(logic [KeyW-1:0] k);
    int b;
    b = dir_bucket[dir_slot(k)];
    for (int j = 0; j < bucket_fill[b]; j++)
      if (bucket_key[b][j] == k) return 1'b1;
    return 1'b0;
  endfunction

  // Split the bucket behind one directory entry; 0 when depth or pool runs out
  function automatic bit split_bucket(int idx);
    int ld, oldb, newb, live, keep, moved;
    ld   = dir_depth[idx];
    oldb = dir_bucket[idx];
    if (ld >= shadow_gdepth) begin
      if (shadow_gdepth >= MaxDepth) return 1'b0;
      live = 1 << shadow_gdepth;
      for (int i = 0; i < live; i++) begin
        dir_depth[i + live]  = dir_depth[i];
        dir_bucket[i + live] = dir_bucket[i];
      end
      shadow_gdepth++;
    end
    if (shadow_used >= DirEntries) return 1'b0;
    newb = shadow_used;
    shadow_used++;
    keep  = 0;
    moved = 0;
    for (int j = 0; j < bucket_fill[oldb]; j++) begin
      if (bucket_key[oldb][j][ld]) begin
        bucket_key[newb][moved] = bucket_key[oldb][j];
        moved++;
      end else begin
        bucket_key[oldb][keep] = bucket_key[oldb][j];
        keep++;
      end
    end
    bucket_fill[oldb] = keep;
    bucket_fill[newb] = moved;
    live = 1 << shadow_gdepth;
    for (int i = idx & ((1 << ld) - 1); i < live; i += (1 << ld)) begin
      dir_depth[i]  = ld + 1;
      dir_bucket[i] = ((i >> ld) & 1) ? newb : oldb;
    end
    return 1'b1;
  endfunction

  function automatic logic [StatusW-1:0] insert_key(logic [KeyW-1:0] k);
    int cap, b;
    cap = (shadow_cap < 1) ? 1 : (shadow_cap > Slots) ? Slots : shadow_cap;
    if (key_present(k)) return StDuplicate;
    for (int guard = 0; guard <= 2 * MaxDepth + 2; guard++) begin
      b = dir_bucket[dir_slot(k)];
      if (bucket_fill[b] < cap) begin
        bucket_key[b][bucket_fill[b]] = k;
        bucket_fill[b]++;
        return StInserted;
      end
      if (!split_bucket(dir_slot(k))) return StFull;
    end
    return StFull;
  endfunction

  function automatic set_result_t predict_request(logic rt, logic [KeyW-1:0] k);
    set_result_t r;
    if (rt == ReqLookup) r.status = key_present(k) ? StFound : StNotFound;
    else r.status = insert_key(k);
    r.depth = DepthOutW'(shadow_gdepth);
    return r;
  endfunction

  // Result side: random stall, long hold-off, compare each beat
  always @(posedge clk_i) begin
    set_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: status %0d depth %0d", status_o, depth_now_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || depth_now_o !== want.depth) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected status %0d depth %0d, got status %0d depth %0d",
                     want.status, want.depth, status_o, depth_now_o);
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offer one request beat and wait until it is taken
  task automatic send_request(logic rt, logic [KeyW-1:0] k);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= rt;
    key_i      <= k;
    do @(posedge clk_i); while (in_stall_o);
    pending_results = {pending_results, predict_request(rt, k)};
    if (rt == ReqInsert) stored_keys = {stored_keys, k};
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CapW-1:0] v);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    shadow_cap = int'(v);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [KeyW-1:0] pick_key();
    unique case ($urandom_range(3))
      0: return KeyW'($urandom);
      1: return {6'($urandom_range(63)), 10'($urandom_range(15))};
      default: begin
        if (stored_keys.size() != 0)
          return stored_keys[$urandom_range(stored_keys.size() - 1)];
        return KeyW'($urandom);
      end
    endcase
  endfunction

  // Basic operations, key extremes and capacity clamping
  task automatic test_directed();
    send_request(ReqLookup, 16'h0000);
    send_request(ReqInsert, 16'h0000);
    send_request(ReqInsert, 16'hFFFF);
    send_request(ReqInsert, 16'h0000);
    send_request(ReqLookup, 16'hFFFF);
    send_request(ReqLookup, 16'h0000);
    send_request(ReqLookup, 16'h5555);
    write_capacity(4'd0);
    for (int i = 1; i <= 5; i++) send_request(ReqInsert, KeyW'(i * 2));
    write_capacity(4'd15);
    for (int i = 0; i < 6; i++) send_request(ReqInsert, KeyW'(16'hAAAA ^ i));
    send_request(ReqLookup, 16'hAAAB);
  endtask

  // Random mixes under each idling pattern and several capacities
  task automatic test_random();
    int phase_send[4]  = '{0, 64, 0, 11};
    int phase_recv[4]  = '{0, 0, 64, 11};
    logic [CapW-1:0] phase_cap[4] = '{4'd8, 4'd1, 4'd3, 4'd5};
    for (int p = 0; p < 4; p++) begin
      write_capacity(p == 3 ? CapW'($urandom_range(8, 1)) : phase_cap[p]);
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      for (int i = 0; i < 170; i++) send_request(logic'($urandom_range(1)), pick_key());
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Hold the result side off so the block backs up, then pause until empty
  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) send_request(logic'($urandom_range(1)), pick_key());
    drain_results();
    for (int i = 0; i < 10; i++) send_request(ReqLookup, pick_key());
  endtask

  // Keys sharing all low directory bits force splits up to the maximum depth
  task automatic test_depth_exhaust();
    write_capacity(4'd1);
    for (int i = 1; i <= 4; i++) send_request(ReqInsert, KeyW'(i << 10) | 16'h0155);
    send_request(ReqLookup, 16'h0D55);
    write_capacity(CapReset);
    for (int i = 0; i < 20; i++) send_request(logic'($urandom_range(1)), pick_key());
  endtask

  initial begin
    shadow_gdepth = 1;
    shadow_used   = 2;
    shadow_cap    = int'(CapReset);
    for (int i = 0; i < DirEntries; i++) begin
      dir_depth[i]   = 0;
      dir_bucket[i]  = 0;
      bucket_fill[i] = 0;
    end
    dir_depth[0]  = 1;
    dir_depth[1]  = 1;
    dir_bucket[1] = 1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    test_depth_exhaust();
    drain_results();
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
